@@ rtl/mbps_pkg.sv @@
// ============================================================================
// mbps_pkg
// Shared types and constants of the masked byte pattern search block.
// ============================================================================
`default_nettype none

package mbps_pkg;

    // Longest pattern and width of the byte offset counter
    localparam int PATTERN_MAX = 16;
    localparam int OFFSET_BITS = 32;

    // Pattern bytes held in the value and mask registers (two 64-bit halves)
    localparam int REG_BYTES   = 16;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_REG_W   = 5;
    localparam int RESULT_W    = 32;

    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int HIST_IDX_W  = $clog2(PATTERN_MAX);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_LOW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_HIGH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH     = 3'd4;

    localparam logic [LEN_REG_W-1:0] LENGTH_RESET = 5'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [RESULT_W-1:0] match_offset;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/masked_byte_pattern_search.sv @@
// ============================================================================
// masked_byte_pattern_search
// Streaming scan for a masked byte signature with one result per buffer.
// ============================================================================
// Bytes of a buffer arrive one per transfer, with last_byte on the final one.
// The block reports the first offset at which all pattern bytes match under
// their care masks, or a not-found result (offset 0) on the last byte; after
// a match the rest of the buffer yields nothing. One byte is taken every
// cycle while the skid is empty; the whole window is compared in parallel
// against the pattern, and a result goes to the output register, or to the
// skid while that register is held. A two-entry output stage (register plus
// skid) keeps input flowing while a result waits. The user must write
// configuration only while the block is idle; the block does not enforce it.
`default_nettype none

module masked_byte_pattern_search (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_write_en,
    input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire mbps_pkg::in_item_t                    in_data,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output mbps_pkg::out_item_t                        out_data
);

    localparam int PMAX  = mbps_pkg::PATTERN_MAX;
    localparam int OBITS = mbps_pkg::OFFSET_BITS;
    localparam int LW    = mbps_pkg::LEN_W;
    localparam int IW    = mbps_pkg::HIST_IDX_W;
    localparam int RB    = mbps_pkg::REG_BYTES;

    localparam logic [OBITS-1:0] COUNT_TOP = '1;

    // Configuration
    logic [mbps_pkg::CFG_DATA_W-1:0] value_low_reg, value_high_reg;
    logic [mbps_pkg::CFG_DATA_W-1:0] mask_low_reg, mask_high_reg;
    logic [mbps_pkg::LEN_REG_W-1:0]  length_reg;

    // Scan state
    logic [7:0]       window_reg [PMAX-1];
    logic [OBITS-1:0] bytes_seen_reg;
    logic             reported_reg;

    // Output stage
    logic                out_valid_reg, skid_valid_reg;
    mbps_pkg::out_item_t out_reg, skid_reg;

    logic [2*mbps_pkg::CFG_DATA_W-1:0] pat_value, pat_mask;
    logic [7:0]          hist [PMAX];
    logic [LW-1:0]       len_eff;
    logic [OBITS-1:0]    count_next;
    logic                all_ok, any_care, match;
    logic                accept, res_valid, out_take;
    mbps_pkg::out_item_t res;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign pat_value = {value_high_reg, value_low_reg};
    assign pat_mask  = {mask_high_reg, mask_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_low_reg  <= '0;
            value_high_reg <= '0;
            mask_low_reg   <= '0;
            mask_high_reg  <= '0;
            length_reg     <= mbps_pkg::LENGTH_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mbps_pkg::CFG_VALUE_LOW:  value_low_reg  <= cfg_data;
                mbps_pkg::CFG_VALUE_HIGH: value_high_reg <= cfg_data;
                mbps_pkg::CFG_MASK_LOW:   mask_low_reg   <= cfg_data;
                mbps_pkg::CFG_MASK_HIGH:  mask_high_reg  <= cfg_data;
                mbps_pkg::CFG_LENGTH:     length_reg     <= cfg_data[mbps_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [LW-1:0] sel;
        logic [7:0]    b, v, m;
        // Clip the length to the window size
        if (32'(length_reg) > PMAX)
            len_eff = LW'(PMAX);
        else
            len_eff = LW'(length_reg);

        count_next = (bytes_seen_reg != COUNT_TOP) ? bytes_seen_reg + 1'b1 : COUNT_TOP;

        // hist[0] is the current byte, hist[k] the byte k positions back
        hist[0] = in_data.data_byte;
        for (int k = 1; k < PMAX; k++)
        begin
            hist[k] = window_reg[k-1];
        end

        all_ok   = 1'b1;
        any_care = 1'b0;
        for (int i = 0; i < PMAX; i++)
        begin
            sel = len_eff - LW'(i) - 1'b1;
            b   = hist[sel[IW-1:0]];
            if (i < RB)
            begin
                v = pat_value[8*i +: 8];
                m = pat_mask[8*i +: 8];
            end
            else
            begin
                v = 8'h00;
                m = 8'h00;
            end
            if (LW'(i) < len_eff)
            begin
                if (m != 8'h00)
                    any_care = 1'b1;
                if ((b & m) != (v & m))
                    all_ok = 1'b0;
            end
        end

        match = !reported_reg && (len_eff != '0) && (count_next >= OBITS'(len_eff))
                && all_ok && any_care;

        res_valid = match || (in_data.last_byte && !reported_reg);
        res.found = match;
        if (match)
            res.match_offset = mbps_pkg::RESULT_W'(count_next - OBITS'(len_eff));
        else
            res.match_offset = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PMAX - 1; k++)
            begin
                window_reg[k] <= 8'h00;
            end
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (in_data.last_byte)
            begin
                // End of buffer: drop history and start over
                for (int k = 0; k < PMAX - 1; k++)
                begin
                    window_reg[k] <= 8'h00;
                end
                bytes_seen_reg <= '0;
                reported_reg   <= 1'b0;
            end
            else
            begin
                window_reg[0] <= in_data.data_byte;
                for (int k = 1; k < PMAX - 1; k++)
                begin
                    window_reg[k] <= window_reg[k-1];
                end
                bytes_seen_reg <= count_next;
                reported_reg   <= reported_reg || match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept && res_valid)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: advance from skid first, else take the new result
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept && res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ============================================================================
// tb
// Testbench for masked_byte_pattern_search.
// ============================================================================
// Byte buffers are streamed through the block under several pattern settings.
// These include the defaults, length zero, oversized lengths, wildcard bytes
// and all-zero masks. A scoreboard keeps its own copy of the pattern
// registers and the byte history. It predicts the single result of each
// buffer and checks every result transfer against the oldest prediction.
// Random gaps on the input side and random stalls on the output side cover
// every phase of the scan. A few stretches run with no idling at all.
// ============================================================================
`default_nettype none

module tb;

    import mbps_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE_CYCLES = 4;

    // ------------------------------------------------------------------------
    // Scoreboard: pattern registers, byte history, queue of predicted results
    // ------------------------------------------------------------------------
    class pattern_scoreboard;
        logic [63:0]         value_lo;
        logic [63:0]         value_hi;
        logic [63:0]         mask_lo;
        logic [63:0]         mask_hi;
        logic [LEN_REG_W-1:0] length_reg;
        logic [7:0]          history [PATTERN_MAX-1];
        logic [OFFSET_BITS-1:0] bytes_taken;
        bit                  reported;
        out_item_t           predicted_q[$];
        int                  errors;

        function new();
            value_lo   = '0;
            value_hi   = '0;
            mask_lo    = '0;
            mask_hi    = '0;
            length_reg = LENGTH_RESET;
            errors     = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (history[i])
                history[i] = 8'h00;
            bytes_taken = '0;
            reported    = 1'b0;
        endfunction

        function void add_prediction(out_item_t r);
            predicted_q = {predicted_q, r};
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_VALUE_LOW:  value_lo = d;
                CFG_VALUE_HIGH: value_hi = d;
                CFG_MASK_LOW:   mask_lo = d;
                CFG_MASK_HIGH:  mask_hi = d;
                CFG_LENGTH:     length_reg = d[LEN_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t item);
            logic [127:0]          vals;
            logic [127:0]          masks;
            logic [OFFSET_BITS-1:0] count;
            logic [7:0]            v;
            logic [7:0]            m;
            logic [7:0]            b;
            int                    len;
            bit                    any_care;
            bit                    ok;
            out_item_t             r;

            vals  = {value_hi, value_lo};
            masks = {mask_hi, mask_lo};
            len   = int'(length_reg);
            if (len > PATTERN_MAX)
                len = PATTERN_MAX;
            count = (bytes_taken != '1) ? bytes_taken + 1'b1 : bytes_taken;

            if (!reported && len > 0 && count >= len)
            begin
                any_care = 1'b0;
                ok       = 1'b1;
                for (int i = 0; i < len; i++)
                begin
                    v = vals[8*i +: 8];
                    m = masks[8*i +: 8];
                    if (i == len - 1)
                        b = item.data_byte;
                    else
                        b = history[len - 2 - i];
                    if (m != 8'h00)
                        any_care = 1'b1;
                    if ((b & m) != (v & m))
                        ok = 1'b0;
                end
                if (ok && any_care)
                begin
                    reported       = 1'b1;
                    r.found        = 1'b1;
                    r.match_offset = RESULT_W'(count - OFFSET_BITS'(len));
                    add_prediction(r);
                end
            end

            if (item.last_byte)
            begin
                if (!reported)
                begin
                    r.found        = 1'b0;
                    r.match_offset = '0;
                    add_prediction(r);
                end
                clear_buffer();
                return;
            end

            for (int i = PATTERN_MAX - 2; i > 0; i--)
                history[i] = history[i - 1];
            history[0]  = item.data_byte;
            bytes_taken = count;
        endfunction

        function void check(out_item_t got);
            out_item_t want;

            if (predicted_q.size() == 0)
            begin
                $error("unexpected result: found=%0d match_offset=%0d",
                       got.found, got.match_offset);
                errors++;
                return;
            end
            want = predicted_q.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.match_offset !== want.match_offset)
            begin
                $error("match_offset: expected %0d, actual %0d",
                       want.match_offset, got.match_offset);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;

    pattern_scoreboard      sb = new();
    bit                     idle_on = 1'b1;
    int                     bytes_sent = 0;

    // Pattern the stimulus is built from; the scoreboard holds its own copy
    logic [7:0]             pat_val  [REG_BYTES];
    logic [7:0]             pat_mask [REG_BYTES];

    masked_byte_pattern_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Record accepted bytes before checking results of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_data);
            if (out_valid && !out_stall)
                sb.check(out_data);
        end
    end

    // Result side: stall for a random stretch, then take one transfer
    initial
    begin
        int hold;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = idle_on ? $urandom_range(0, 19) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input bit last);
        int       gap;
        in_item_t item;

        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_byte = d;
        item.last_byte = last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] frame[$]);
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    task automatic load_pattern(input logic [LEN_REG_W-1:0] len);
        logic [63:0] lo_v;
        logic [63:0] hi_v;
        logic [63:0] lo_m;
        logic [63:0] hi_m;
        logic [63:0] len_word;

        for (int i = 0; i < 8; i++)
        begin
            lo_v[8*i +: 8] = pat_val[i];
            hi_v[8*i +: 8] = pat_val[i + 8];
            lo_m[8*i +: 8] = pat_mask[i];
            hi_m[8*i +: 8] = pat_mask[i + 8];
        end
        // Upper bits of the length word are junk the block must drop
        len_word = {$urandom, $urandom};
        len_word[LEN_REG_W-1:0] = len;
        write_reg(CFG_VALUE_LOW, lo_v);
        write_reg(CFG_VALUE_HIGH, hi_v);
        write_reg(CFG_MASK_LOW, lo_m);
        write_reg(CFG_MASK_HIGH, hi_m);
        write_reg(CFG_LENGTH, len_word);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [7:0] match_byte(int i);
        logic [7:0] noise;

        noise = 8'($urandom);
        return (pat_val[i] & pat_mask[i]) | (noise & ~pat_mask[i]);
    endfunction

    function automatic void random_pattern();
        int style;

        style = $urandom_range(0, 7);
        for (int i = 0; i < REG_BYTES; i++)
        begin
            pat_val[i] = 8'($urandom);
            case (style)
                0, 1:    pat_mask[i] = 8'hFF;
                2, 3:    pat_mask[i] = 8'($urandom);
                7:       pat_mask[i] = 8'h00;
                default: pat_mask[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            endcase
        end
    endfunction

    // Random buffer, mostly holding the pattern, sometimes a broken prefix
    task automatic random_frame(input int eff);
        logic [7:0] frame[$];
        int         blen;
        int         pos;
        int         cut;

        blen = $urandom_range(1, 3 * eff + 8);
        frame.delete();
        for (int i = 0; i < blen; i++)
            frame = {frame, 8'($urandom)};
        if ($urandom_range(0, 2) == 0 && eff > 1 && blen > eff)
        begin
            cut = $urandom_range(1, eff - 1);
            pos = $urandom_range(0, blen - cut);
            for (int i = 0; i < cut; i++)
                frame[pos + i] = match_byte(i);
        end
        if ($urandom_range(0, 9) < 7 && blen >= eff)
        begin
            pos = $urandom_range(0, blen - eff);
            for (int i = 0; i < eff; i++)
                frame[pos + i] = match_byte(i);
        end
        send_frame(frame);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0]           frame[$];
        logic [LEN_REG_W-1:0] len;
        int                   eff;
        int                   frames;
        int                   target;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern: length one, all-zero mask, so nothing matches
        frame = '{8'h00, 8'hFF};
        send_frame(frame);
        drain();

        for (int i = 0; i < REG_BYTES; i++)
        begin
            pat_val[i]  = 8'($urandom);
            pat_mask[i] = 8'hFF;
        end
        pat_val[0] = 8'hAA;
        pat_val[1] = 8'hBB;
        pat_val[2] = 8'hCC;
        load_pattern(5'd3);
        // Match at offset one, trailing bytes ignored
        frame = '{8'h11, 8'hAA, 8'hBB, 8'hCC, 8'h22, 8'h33};
        send_frame(frame);
        // Buffer shorter than the pattern
        frame = '{8'hAA, 8'hBB};
        send_frame(frame);
        // Match completes on the last byte
        frame = '{8'hAA, 8'hBB, 8'hCC};
        send_frame(frame);
        drain();

        // Length zero never matches
        load_pattern(5'd0);
        frame = '{8'hAA, 8'hBB, 8'hCC};
        send_frame(frame);
        drain();

        // Oversized length is cut to the full sixteen bytes, some wildcards
        for (int i = 0; i < REG_BYTES; i++)
        begin
            pat_val[i]  = 8'($urandom);
            pat_mask[i] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
        end
        pat_mask[0] = 8'hFF;
        load_pattern(5'd31);
        frame.delete();
        for (int i = 0; i < REG_BYTES; i++)
            frame = {frame, match_byte(i)};
        send_frame(frame);
        drain();

        target = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < target)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            random_pattern();
            case ($urandom_range(0, 9))
                0:       len = 5'd0;
                1:       len = 5'($urandom_range(PATTERN_MAX, 31));
                2:       len = 5'($urandom_range(7, PATTERN_MAX));
                default: len = 5'($urandom_range(1, 6));
            endcase
            // Writes to indexes past the last register are ignored
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'(CFG_LENGTH + $urandom_range(1, 3)),
                          {$urandom, $urandom});
            load_pattern(len);
            eff = (len == 0) ? 1 : ((len > PATTERN_MAX) ? PATTERN_MAX : int'(len));
            frames = $urandom_range(3, 8);
            repeat (frames) random_frame(eff);
            drain();
        end

        idle_on = 1'b1;
        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/mbps_pkg.sv
rtl/masked_byte_pattern_search.sv
bench/tb.sv
